// ===== hdl/acfb_pkg.sv =====
`timescale 1ns / 1ps

package acfb_pkg;

  localparam int unsigned BlockBytes = 16;
  localparam int unsigned NumRounds  = 10;

  typedef enum logic [1:0] {
    CfgKeyUpper = 2'd0,
    CfgKeyLower = 2'd1,
    CfgIvUpper  = 2'd2,
    CfgIvLower  = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    StIdle,
    StKeyExp,
    StRound,
    StOut
  } state_e;

  typedef struct packed {
    logic         start;
    logic [127:0] key;
    logic [127:0] block;
  } core_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] block;
  } core_rsp_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a big-endian 128-bit block
  function automatic logic [7:0] blk_byte(input logic [127:0] b, input logic [3:0] i);
    return b[8'(127 - 8 * i) -: 8];
  endfunction

endpackage

// ===== hdl/acfb_stream_if.sv =====
`timescale 1ns / 1ps

interface acfb_stream_if #(
  parameter int unsigned Width = 8
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/acfb_aes_core.sv =====
`timescale 1ns / 1ps

// iterative aes-128 encryption, one round per cycle, round key made on the fly
module acfb_aes_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  acfb_pkg::core_req_t  req_i,
  output acfb_pkg::core_rsp_t  rsp_o
);

  logic [127:0] state_q, state_d;
  logic [127:0] rkey_q, rkey_d;
  logic [7:0]   rcon_q, rcon_d;
  logic [3:0]   round_q, round_d;
  logic         busy_q, busy_d;
  logic         done_q, done_d;

  logic [127:0] sub_sh, mixed, rnext;
  logic [31:0]  rot;

  always_comb begin
    // sub bytes and shift rows
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sub_sh[127 - 8 * (c * 4 + r) -: 8] =
          acfb_pkg::sbox(state_q[127 - 8 * (((c + r) % 4) * 4 + r) -: 8]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3, all;
      a0  = sub_sh[127 - 32 * c -: 8];
      a1  = sub_sh[119 - 32 * c -: 8];
      a2  = sub_sh[111 - 32 * c -: 8];
      a3  = sub_sh[103 - 32 * c -: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      mixed[127 - 32 * c -: 8] = a0 ^ all ^ acfb_pkg::xtime(a0 ^ a1);
      mixed[119 - 32 * c -: 8] = a1 ^ all ^ acfb_pkg::xtime(a1 ^ a2);
      mixed[111 - 32 * c -: 8] = a2 ^ all ^ acfb_pkg::xtime(a2 ^ a3);
      mixed[103 - 32 * c -: 8] = a3 ^ all ^ acfb_pkg::xtime(a3 ^ a0);
    end
    // next round key
    rot = {acfb_pkg::sbox(rkey_q[23:16]) ^ rcon_q, acfb_pkg::sbox(rkey_q[15:8]),
           acfb_pkg::sbox(rkey_q[7:0]), acfb_pkg::sbox(rkey_q[31:24])};
    rnext[127:96] = rkey_q[127:96] ^ rot;
    rnext[95:64]  = rkey_q[95:64] ^ rnext[127:96];
    rnext[63:32]  = rkey_q[63:32] ^ rnext[95:64];
    rnext[31:0]   = rkey_q[31:0] ^ rnext[63:32];
  end

  always_comb begin
    state_d = state_q;
    rkey_d  = rkey_q;
    rcon_d  = rcon_q;
    round_d = round_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      state_d = req_i.block ^ req_i.key;
      rkey_d  = req_i.key;
      rcon_d  = 8'h01;
      round_d = 4'd1;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      state_d = ((round_q == 4'(acfb_pkg::NumRounds)) ? sub_sh : mixed) ^ rnext;
      rkey_d  = rnext;
      rcon_d  = acfb_pkg::xtime(rcon_q);
      round_d = round_q + 4'd1;
      if (round_q == 4'(acfb_pkg::NumRounds)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      round_q <= '0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      round_q <= round_d;
    end
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d;
    rkey_q  <= rkey_d;
    rcon_q  <= rcon_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.block = state_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("done while busy");
  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (round_q != 4'd0)) else $error("bad round");
  a_done_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> $past(busy_q)) else $error("done without work");

endmodule

// ===== hdl/aes128_cfb_byte_cipher_unit.sv =====
`timescale 1ns / 1ps

// aes-128 cfb128 byte stream cipher
// channels: in_ch carries {mode, data_byte, message_end}, out_ch carries
// {result_byte, result_last}, cfg_ch carries an 8-bit register index and a
// 64-bit value (key upper, key lower, iv upper, iv lower); other indexes are
// ignored.
// a word is taken whenever the sequencer is idle. a word at byte position
// zero starts an aes encryption of the feedback block on a shared round unit,
// one round per cycle with the round key made on the fly; its result is
// registered once the round unit is done and the output register is free;
// the next word is taken after that. other words go from accept straight to
// the result register, again once the output register is free.
// key and iv are latched on a message's first word; after the word marked
// message_end, feedback returns to the iv and the position to zero.
// reset loads the documented key and iv and clears all control state.
// if the receiver stalls, the result waits in the output register; the next
// word is still taken and held until the register frees, and no further word
// is taken until it has moved into the register.
module aes128_cfb_byte_cipher_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  acfb_stream_if.sink   in_ch,
  acfb_stream_if.source out_ch,
  acfb_stream_if.sink   cfg_ch
);

  logic [63:0]  cfg_value;
  logic [1:0]   cfg_index;
  logic [127:0] key_q, key_d, iv_q, iv_d;
  logic [127:0] fb_q, fb_d, ks_q, ks_d, run_key_q, run_key_d;
  logic [3:0]   pos_q, pos_d;
  logic         active_q, active_d;
  logic         mode_q, mode_d, last_q, last_d;
  logic [7:0]   data_q, data_d;
  logic [7:0]   res_q, res_d;
  logic         res_last_q, res_last_d;
  logic         ovalid_q, ovalid_d;
  acfb_pkg::state_e state_q, state_d;
  acfb_pkg::core_req_t req;
  acfb_pkg::core_rsp_t rsp;
  logic [127:0] ks_use;
  logic [7:0]   res_c, fbb;
  logic         out_free;

  assign cfg_index    = cfg_ch.data[65:64];
  assign cfg_value    = cfg_ch.data[63:0];
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    key_d = key_q;
    iv_d  = iv_q;
    if (cfg_ch.valid && cfg_ch.data[71:66] == '0) begin
      unique case (acfb_pkg::cfg_reg_e'(cfg_index))
        acfb_pkg::CfgKeyUpper: key_d[127:64] = cfg_value;
        acfb_pkg::CfgKeyLower: key_d[63:0]   = cfg_value;
        acfb_pkg::CfgIvUpper:  iv_d[127:64]  = cfg_value;
        acfb_pkg::CfgIvLower:  iv_d[63:0]    = cfg_value;
        default: ;
      endcase
    end
  end

  acfb_aes_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // output register is free when empty or emptied at this edge
  assign out_free     = !ovalid_q || out_ch.ready;
  assign in_ch.ready  = (state_q == acfb_pkg::StIdle);
  assign out_ch.valid = ovalid_q;
  assign out_ch.data  = {res_q, res_last_q};

  // keystream comes straight from the core on the cycle it finishes
  assign ks_use = rsp.done ? rsp.block : ks_q;
  assign res_c  = data_q ^ acfb_pkg::blk_byte(ks_use, pos_q);
  assign fbb    = mode_q ? res_c : data_q;

  always_comb begin
    state_d    = state_q;
    fb_d       = fb_q;
    ks_d       = ks_q;
    run_key_d  = run_key_q;
    pos_d      = pos_q;
    active_d   = active_q;
    mode_d     = mode_q;
    last_d     = last_q;
    data_d     = data_q;
    res_d      = res_q;
    res_last_d = res_last_q;
    ovalid_d   = ovalid_q;
    req.start  = 1'b0;
    req.key    = run_key_q;
    req.block  = fb_q;
    if (out_ch.valid && out_ch.ready) ovalid_d = 1'b0;
    unique case (state_q)
      acfb_pkg::StIdle: begin
        if (in_ch.valid && in_ch.ready) begin
          mode_d = in_ch.data[9];
          data_d = in_ch.data[8:1];
          last_d = in_ch.data[0];
          if (!active_q) begin
            fb_d      = iv_q;
            run_key_d = key_q;
            pos_d     = '0;
            active_d  = 1'b1;
            state_d   = acfb_pkg::StKeyExp;
          end else if (pos_q == '0) begin
            state_d = acfb_pkg::StKeyExp;
          end else begin
            state_d = acfb_pkg::StOut;
          end
        end
      end
      acfb_pkg::StKeyExp: begin
        req.start = 1'b1;
        state_d   = acfb_pkg::StRound;
      end
      acfb_pkg::StRound: begin
        if (rsp.done) begin
          ks_d    = rsp.block;
          state_d = acfb_pkg::StOut;
        end
      end
      acfb_pkg::StOut: begin
        // hold the word until the output register can take its result
        if (out_free) begin
          res_d      = res_c;
          res_last_d = last_q;
          ovalid_d   = 1'b1;
          fb_d[8'(127 - 8 * pos_q) -: 8] = fbb;
          pos_d      = pos_q + 4'd1;
          if (last_q) begin
            fb_d     = iv_q;
            pos_d    = '0;
            active_d = 1'b0;
          end
          state_d = acfb_pkg::StIdle;
        end
      end
      default: state_d = acfb_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= acfb_pkg::StIdle;
      key_q    <= 128'h000102030405060708090a0b0c0d0e0f;
      iv_q     <= 128'ha0a1a2a3a4a5a6a7a8a9aaabacadaeaf;
      fb_q     <= 128'ha0a1a2a3a4a5a6a7a8a9aaabacadaeaf;
      pos_q    <= '0;
      active_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      key_q    <= key_d;
      iv_q     <= iv_d;
      fb_q     <= fb_d;
      pos_q    <= pos_d;
      active_q <= active_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ks_q       <= ks_d;
    run_key_q  <= run_key_d;
    mode_q     <= mode_d;
    last_q     <= last_d;
    data_q     <= data_d;
    res_q      <= res_d;
    res_last_q <= res_last_d;
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != acfb_pkg::StIdle) |-> !in_ch.ready) else $error("accept while busy");
  a_out_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(state_q == acfb_pkg::StOut)) else $error("stray result");
  a_pos_reset_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == acfb_pkg::StOut && last_q && out_free) |=> (pos_q == '0 && !active_q))
    else $error("message end not handled");
  a_core_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> (state_q == acfb_pkg::StRound)) else $error("unexpected keystream");

endmodule

// ===== verif/aes128_cfb_byte_cipher_unit_tb.sv =====
`timescale 1ns / 1ps

module aes128_cfb_byte_cipher_unit_tb;

  // predicts the cfb128 result words and keeps those still due
  class cfb_stream_predictor;
    typedef struct {
      logic [7:0] res_byte;
      logic       res_last;
    } result_t;

    logic [7:0] sb [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    logic [63:0] key_hi, key_lo, iv_hi, iv_lo;
    logic [7:0]  sched [176];
    logic [7:0]  fb [16];
    logic [7:0]  ks [16];
    logic [3:0]  pos;
    logic        in_msg;
    result_t     pending [$];
    int          mismatches;

    function new();
      key_hi = 64'h0001020304050607;
      key_lo = 64'h08090A0B0C0D0E0F;
      iv_hi  = 64'hA0A1A2A3A4A5A6A7;
      iv_lo  = 64'hA8A9AAABACADAEAF;
      pos    = '0;
      in_msg = 1'b0;
      mismatches = 0;
    endfunction

    // indexes beyond the four registers are ignored
    function void write_reg(logic [7:0] idx, logic [63:0] val);
      if (idx[7:2] != '0) return;
      case (acfb_pkg::cfg_reg_e'(idx[1:0]))
        acfb_pkg::CfgKeyUpper: key_hi = val;
        acfb_pkg::CfgKeyLower: key_lo = val;
        acfb_pkg::CfgIvUpper:  iv_hi = val;
        acfb_pkg::CfgIvLower:  iv_lo = val;
        default: ;
      endcase
    endfunction

    function void load_iv();
      logic [127:0] iv;
      iv = {iv_hi, iv_lo};
      for (int i = 0; i < 16; i++) fb[i] = iv[127 - 8 * i -: 8];
    endfunction

    function void expand_key();
      logic [127:0] k;
      logic [7:0]   t [4];
      logic [7:0]   f;
      logic [7:0]   rc;
      k  = {key_hi, key_lo};
      rc = 8'h01;
      for (int i = 0; i < 16; i++) sched[i] = k[127 - 8 * i -: 8];
      for (int i = 16; i < 176; i += 4) begin
        for (int j = 0; j < 4; j++) t[j] = sched[i - 4 + j];
        if (i % 16 == 0) begin
          f    = t[0];
          t[0] = sb[t[1]] ^ rc;
          t[1] = sb[t[2]];
          t[2] = sb[t[3]];
          t[3] = sb[f];
          rc   = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
        end
        for (int j = 0; j < 4; j++) sched[i + j] = sched[i - 16 + j] ^ t[j];
      end
    endfunction

    function logic [7:0] dbl(logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // one aes-128 encryption of the feedback block into ks
    function void encrypt_feedback();
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, x;
      for (int i = 0; i < 16; i++) s[i] = fb[i] ^ sched[i];
      for (int r = 1; r <= 10; r++) begin
        for (int c = 0; c < 4; c++)
          for (int w = 0; w < 4; w++) t[c * 4 + w] = sb[s[((c + w) % 4) * 4 + w]];
        s = t;
        if (r < 10) begin
          for (int c = 0; c < 4; c++) begin
            a0 = s[c*4]; a1 = s[c*4+1]; a2 = s[c*4+2]; a3 = s[c*4+3];
            x  = a0 ^ a1 ^ a2 ^ a3;
            s[c*4]   = a0 ^ x ^ dbl(a0 ^ a1);
            s[c*4+1] = a1 ^ x ^ dbl(a1 ^ a2);
            s[c*4+2] = a2 ^ x ^ dbl(a2 ^ a3);
            s[c*4+3] = a3 ^ x ^ dbl(a3 ^ a0);
          end
        end
        for (int i = 0; i < 16; i++) s[i] ^= sched[r * 16 + i];
      end
      ks = s;
    endfunction

    // an accepted input word
    function void note_word(logic enc, logic [7:0] din, logic last);
      result_t rw;
      if (!in_msg) begin
        load_iv();
        expand_key();
        pos    = '0;
        in_msg = 1'b1;
      end
      if (pos == 0) encrypt_feedback();
      rw.res_byte = din ^ ks[pos];
      rw.res_last = last;
      fb[pos] = enc ? rw.res_byte : din;
      pos++;
      if (last) begin
        load_iv();
        pos    = '0;
        in_msg = 1'b0;
      end
      pending = {pending, rw};
    endfunction

    // an accepted result word
    function void check_word(logic [7:0] rb, logic rl);
      result_t ew;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word byte=%h last=%b", rb, rl);
        return;
      end
      ew = pending.pop_front();
      if (ew.res_byte !== rb || ew.res_last !== rl) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: exp byte=%h last=%b, got byte=%h last=%b",
                   ew.res_byte, ew.res_last, rb, rl);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  // in: {mode, data byte, end}, out: {result byte, last}, cfg: {index, value}
  acfb_stream_if #(.Width(10)) in_if ();
  acfb_stream_if #(.Width(9))  out_if ();
  acfb_stream_if #(.Width(72)) cfg_if ();

  aes128_cfb_byte_cipher_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_if.sink),
    .out_ch (out_if.source),
    .cfg_ch (cfg_if.sink)
  );

  cfb_stream_predictor keystream_pred = new();

  // idling on/off and the one long receiver hold-off
  logic idle_on;
  logic squeeze_req;
  int   words_sent;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // hard limit on run time
  initial begin
    #20ms;
    $display("aes128_cfb_byte_cipher_unit regression: fail");
    $finish;
  end

  // watch both input channels and feed the predictor; check each taken result word
  always @(posedge clk_i) begin
    if (rst_ni && cfg_if.valid && cfg_if.ready)
      keystream_pred.write_reg(cfg_if.data[71:64], cfg_if.data[63:0]);
    if (rst_ni && in_if.valid && in_if.ready)
      keystream_pred.note_word(in_if.data[9], in_if.data[8:1], in_if.data[0]);
    if (rst_ni && out_if.valid && out_if.ready)
      keystream_pred.check_word(out_if.data[8:1], out_if.data[0]);
  end

  function automatic int pick_gap();
    if (!idle_on) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(8, 40);
    return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int  stall;
    int  hold;
    bit  held_once;
    stall = 0;
    hold = 0;
    held_once = 0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (squeeze_req && !held_once) begin
        held_once = 1;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_if.ready <= 1'b0;
      end else begin
        stall = pick_gap();
        out_if.ready <= (stall == 0);
      end
    end
  end

  // one input word; valid stays up between back-to-back words
  task automatic send_word(logic enc, logic [7:0] din, logic last);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= {enc, din, last};
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    words_sent++;
  endtask

  // mode_sel: 0 decrypt, 1 encrypt, 2 per-word random
  // fill: 0 random, 1 all zeros, 2 all ones
  task automatic send_message(int len, int mode_sel, int fill, bit with_end);
    logic       enc;
    logic [7:0] din;
    for (int i = 0; i < len; i++) begin
      enc = (mode_sel == 2) ? 1'($urandom_range(0, 1)) : 1'(mode_sel);
      din = (fill == 1) ? 8'h00 : (fill == 2) ? 8'hff : 8'($urandom);
      send_word(enc, din, with_end && (i == len - 1));
    end
  endtask

  // let outstanding words drain, then the round unit settle
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (keystream_pred.pending.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(acfb_pkg::cfg_reg_e idx, logic [63:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= {6'd0, idx, val};
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all(logic [63:0] k0, logic [63:0] k1, logic [63:0] v0,
                           logic [63:0] v1);
    write_reg(acfb_pkg::CfgKeyUpper, k0);
    write_reg(acfb_pkg::CfgKeyLower, k1);
    write_reg(acfb_pkg::CfgIvUpper, v0);
    write_reg(acfb_pkg::CfgIvLower, v1);
  endtask

  // random messages of mostly short length until the word budget is used
  task automatic random_traffic(int budget);
    int stop_at;
    int len;
    stop_at = words_sent + budget;
    while (words_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0:       len = 16;
        1:       len = $urandom_range(17, 48);
        default: len = $urandom_range(1, 20);
      endcase
      send_message(len, $urandom_range(0, 2), 0, 1);
    end
  endtask

  initial begin
    int setting;
    rst_ni       = 1'b0;
    idle_on      = 1'b1;
    squeeze_req  = 1'b0;
    words_sent   = 0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset key and iv, single-word message, data extremes
    send_message(1, 1, 1, 1);
    send_message(1, 0, 2, 1);
    // exactly one block then one byte past the boundary
    send_message(16, 1, 2, 1);
    send_message(17, 0, 1, 1);
    // short final block, mode picked at random per word
    send_message(5, 2, 0, 1);
    wait_idle();

    // key and iv written mid-message must only take effect at the next one
    send_message(3, 1, 0, 0);
    wait_idle();
    write_all('0, '0, '0, '0);
    send_message(2, 0, 0, 1);
    send_message(3, 1, 0, 1);
    wait_idle();
    write_all('1, '1, '1, '1);
    send_message(2, 2, 2, 1);
    wait_idle();

    // random phases across several key and iv settings
    for (setting = 0; setting < 5; setting++) begin
      case (setting)
        0: write_all('0, '0, '0, '0);
        1: write_all('1, '1, '1, '1);
        2: write_all(64'h0001020304050607, 64'h08090A0B0C0D0E0F,
                     64'hA0A1A2A3A4A5A6A7, 64'hA8A9AAABACADAEAF);
        default: write_all({$urandom, $urandom}, {$urandom, $urandom},
                           {$urandom, $urandom}, {$urandom, $urandom});
      endcase
      idle_on = (setting != 2);
      // long receiver hold-off while the sender keeps offering
      if (setting == 3) squeeze_req <= 1'b1;
      random_traffic(70);
      wait_idle();
    end

    in_if.valid <= 1'b0;
    repeat (40) @(posedge clk_i);
    if (keystream_pred.mismatches == 0 && keystream_pred.pending.size() == 0) begin
      $display("aes128_cfb_byte_cipher_unit regression: pass");
    end else begin
      $display("aes128_cfb_byte_cipher_unit regression: fail");
    end
    $finish;
  end

endmodule
